[hdl/oeas_pkg.sv]
// shared constants, register map and reciprocal table for the adaptive smoother
`default_nettype none
package oeas_pkg;

	localparam int VALUE_WIDTH_DEF   = 32;
	localparam int FRACTION_BITS_DEF = 16;

	localparam int TIME_BITS = 21;
	localparam int TIME_FRAC = 20;
	localparam int CFG_WIDTH = 16;
	localparam int ADDR_WIDTH = 4;
	localparam int TAYLOR_TERMS = 13;

	// 2*pi in Q24 and exp(-1) in Q32
	localparam logic [31:0] TWO_PI_Q24 = 32'd105414357;
	localparam logic [31:0] EXP_M1_Q32 = 32'd1580030169;

	localparam logic [1:0] REG_MIN_CUTOFF        = 2'd0;
	localparam logic [1:0] REG_DERIVATIVE_CUTOFF = 2'd1;
	localparam logic [1:0] REG_SPEED_GAIN        = 2'd2;

	// floor((2^32-1)/n), the quotient is corrected afterwards
	function automatic logic [31:0] oeas_recip(input logic [3:0] n);
		logic [31:0] m;
		unique case (n)
			4'd1:    m = 32'd4294967295;
			4'd2:    m = 32'd2147483647;
			4'd3:    m = 32'd1431655765;
			4'd4:    m = 32'd1073741823;
			4'd5:    m = 32'd858993459;
			4'd6:    m = 32'd715827882;
			4'd7:    m = 32'd613566756;
			4'd8:    m = 32'd536870911;
			4'd9:    m = 32'd477218588;
			4'd10:   m = 32'd429496729;
			4'd11:   m = 32'd390451572;
			4'd12:   m = 32'd357913941;
			4'd13:   m = 32'd330382099;
			default: m = 32'd0;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

[hdl/oeas_in_if.sv]
// input channel: sample and time step with valid/ready
`default_nettype none
interface oeas_in_if
	import oeas_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] sample;
	logic [TIME_BITS-1:0]   time_step;

	modport source (output valid, output sample, output time_step, input ready);
	modport sink (input valid, input sample, input time_step, output ready);
endinterface
`default_nettype wire

[hdl/oeas_out_if.sv]
// output channel: filtered value and flags with valid/ready
`default_nettype none
interface oeas_out_if
	import oeas_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] filtered;
	logic                   passthrough;
	logic                   step_error;

	modport source (output valid, output filtered, output passthrough, output step_error,
		input ready);
	modport sink (input valid, input filtered, input passthrough, input step_error,
		output ready);
endinterface
`default_nettype wire

[hdl/one_euro_adaptive_smoother.sv]
// one euro style adaptive smoother on a shared multiplier under a sequencer
//
// usage: requests enter on in_ch (sample, time_step) and leave on out_ch
// (filtered, passthrough, step_error), one result per request, in order.
// the apb port sets min_cutoff (0x0), derivative_cutoff (0x4) and speed_gain (0x8);
// write it only while the block is idle.
// a seeding request or a zero step answers in the cycle after acceptance.
// a normal request runs the bit-serial divider (one quotient bit a cycle), then
// for each of the two exponent arguments that is in range the 13-term series on
// the single multiplier and one multiply per exp(-1) factor, one factor for each
// unit of the integer part of that argument.
// the block takes one request at a time: in_ch.ready is high only when idle,
// and a result held on out_ch waits there for as long as the receiver stalls.
// reset (arst_n low) clears the filter state to unprimed and loads the
// register defaults; the first request after it seeds the state.
`default_nettype none
module one_euro_adaptive_smoother
	import oeas_pkg::*;
#(
	parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	oeas_in_if.sink                    in_ch,
	oeas_out_if.source                 out_ch,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [ADDR_WIDTH-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready
);

	localparam int VW   = VALUE_WIDTH;
	localparam int FB   = FRACTION_BITS;
	// multiplier operand a must hold a 33-bit series term or a blend difference
	localparam int AW   = (VW + 1 > 33) ? VW + 1 : 33;
	localparam int PW   = AW + 32;
	// quotient bits of the derivative divide
	localparam int QW   = VW + 1;
	localparam int CNTW = $clog2(QW);
	// cutoff width: min_cutoff plus the scaled derivative term
	localparam int CW   = ((VW + 16 - FB > 16) ? VW + 16 - FB : 16) + 1;
	localparam int CWX  = (CW > 34) ? CW : 34;

	typedef enum logic [4:0] {
		S_IDLE, S_SETUP, S_DIV, S_RATE,
		S_P, S_X, S_XR, S_T1, S_T2, S_T3, S_K, S_K2, S_W,
		S_BLEND, S_BL2, S_CUT, S_CUT2, S_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic [CFG_WIDTH-1:0] min_cutoff_q, derivative_cutoff_q, speed_gain_q;

	// filter state
	logic          primed_q;
	logic [VW-1:0] prev_q, sd_q, sv_q;

	// result register
	logic [VW-1:0] filtered_q;
	logic          pass_q, err_q;

	// working registers
	logic [VW-1:0]        x_q;
	logic [TIME_BITS-1:0] dt_q;
	logic                 neg_q;
	logic [QW-1:0]        num_q, quo_q;
	logic [TIME_BITS-1:0] rem_q;
	logic [CNTW-1:0]      cnt_q;
	logic [VW-1:0]        rate_q;
	logic [CW-1:0]        cut_q;
	logic                 value_phase_q;
	logic [PW-1:0]        prod_q;
	logic [6:0]           k_q;
	logic [31:0]          f_q;
	logic [32:0]          t_q, v_q, r_q;
	logic [34:0]          sum_q;
	logic [3:0]           n_q;
	logic [16:0]          w_q;

	// ---------------- apb ----------------
	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_comb begin
		unique case (paddr[3:2])
			REG_MIN_CUTOFF:        prdata = 32'(min_cutoff_q);
			REG_DERIVATIVE_CUTOFF: prdata = 32'(derivative_cutoff_q);
			REG_SPEED_GAIN:        prdata = 32'(speed_gain_q);
			default:               prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_cutoff_q        <= CFG_WIDTH'(256);
			derivative_cutoff_q <= CFG_WIDTH'(256);
			speed_gain_q        <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_MIN_CUTOFF:        min_cutoff_q        <= pwdata[CFG_WIDTH-1:0];
				REG_DERIVATIVE_CUTOFF: derivative_cutoff_q <= pwdata[CFG_WIDTH-1:0];
				REG_SPEED_GAIN:        speed_gain_q        <= pwdata[CFG_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- datapath helpers ----------------
	// sample difference and the divide set-up
	logic [VW:0]    diff, diff_mag;
	logic           diff_neg;
	logic [VW+20:0] num_full;
	logic [19:0]    num_top;
	logic           div_sat;
	assign diff     = {x_q[VW-1], x_q} - {prev_q[VW-1], prev_q};
	assign diff_neg = diff[VW];
	assign diff_mag = diff_neg ? (~diff + 1'b1) : diff;
	assign num_full = {diff_mag, 20'd0};
	assign num_top  = num_full[VW+20 -: 20];
	// quotient would not fit in QW bits: saturate
	assign div_sat  = {1'b0, num_top} >= dt_q;

	// one restoring divide step
	logic [TIME_BITS:0] div_sh, div_sub;
	logic               div_ge;
	assign div_sh  = {rem_q, num_q[QW-1]};
	assign div_sub = div_sh - {1'b0, dt_q};
	assign div_ge  = div_sh >= {1'b0, dt_q};

	// rate clamp to the signed range
	logic [QW-1:0] rate_lim, rate_mag, rate_full;
	assign rate_lim  = neg_q ? (QW'(1) << (VW - 1)) : ((QW'(1) << (VW - 1)) - QW'(1));
	assign rate_mag  = (quo_q > rate_lim) ? rate_lim : quo_q;
	assign rate_full = neg_q ? (~rate_mag + 1'b1) : rate_mag;

	// cutoff cap
	logic [CWX-1:0] cut_x;
	logic           cut_big;
	assign cut_x   = CWX'(cut_q);
	assign cut_big = cut_x > (CWX'(1) << 32);

	// exponent argument with rounding
	logic [PW-1:0] x_round;
	assign x_round = prod_q + (PW'(1) << 35);

	// series term: reciprocal quotient and its correction
	logic [32:0] q0, qn, rr, nn, q_fix;
	logic [34:0] sum_new;
	assign q0      = prod_q[64:32];
	assign nn      = 33'(n_q);
	assign qn      = 33'(q0 * nn);
	assign rr      = v_q - qn;
	assign q_fix   = q0 + 33'(rr >= nn) + 33'(rr >= (nn << 1)) + 33'(rr >= 33'(nn * 33'd3));
	assign sum_new = n_q[0] ? (sum_q - 35'(q_fix)) : (sum_q + 35'(q_fix));

	// weight rounding to q16
	logic [33:0] w_round;
	assign w_round = {1'b0, r_q} + 34'(1 << 15);

	// blend operands, derivative first then value
	logic [VW-1:0] bl_in, bl_prev;
	logic [VW:0]   bl_d, bl_mag, bl_in_ext, bl_adj, bl_res;
	logic          bl_neg;
	logic [PW-1:0] adj_round;
	assign bl_in     = value_phase_q ? x_q : rate_q;
	assign bl_prev   = value_phase_q ? sv_q : sd_q;
	assign bl_in_ext = {bl_in[VW-1], bl_in};
	assign bl_d      = {bl_prev[VW-1], bl_prev} - bl_in_ext;
	assign bl_neg    = bl_d[VW];
	assign bl_mag    = bl_neg ? (~bl_d + 1'b1) : bl_d;
	assign adj_round = prod_q + (PW'(1) << 15);
	assign bl_adj    = adj_round[16 +: QW];
	// result always lies between the two inputs
	assign bl_res    = bl_neg ? (bl_in_ext - bl_adj) : (bl_in_ext + bl_adj);

	logic [VW-1:0] sd_mag;
	assign sd_mag = sd_q[VW-1] ? (~sd_q + 1'b1) : sd_q;

	// ---------------- shared multiplier ----------------
	logic [AW-1:0] mul_a;
	logic [31:0]   mul_b;

	always_comb begin
		unique case (state_q)
			S_P: begin
				mul_a = AW'(cut_x[32:0]);
				mul_b = 32'(dt_q);
			end
			S_X: begin
				mul_a = AW'(prod_q[30:0]);
				mul_b = TWO_PI_Q24;
			end
			S_T1: begin
				mul_a = AW'(t_q);
				mul_b = f_q;
			end
			S_T2: begin
				mul_a = AW'(prod_q[64:32]);
				mul_b = oeas_recip(n_q);
			end
			S_K: begin
				mul_a = AW'(r_q);
				mul_b = EXP_M1_Q32;
			end
			S_BLEND: begin
				mul_a = AW'(bl_mag);
				mul_b = 32'(w_q);
			end
			S_CUT: begin
				mul_a = AW'(sd_mag);
				mul_b = 32'(speed_gain_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			primed_q      <= 1'b0;
			prev_q        <= '0;
			sd_q          <= '0;
			sv_q          <= '0;
			filtered_q    <= '0;
			pass_q        <= 1'b0;
			err_q         <= 1'b0;
			value_phase_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						if (!primed_q) begin
							// seeding request passes straight through
							prev_q     <= in_ch.sample;
							sv_q       <= in_ch.sample;
							sd_q       <= '0;
							primed_q   <= in_ch.time_step != '0;
							filtered_q <= in_ch.sample;
							pass_q     <= 1'b1;
							err_q      <= 1'b0;
							state_q    <= S_OUT;
						end else if (in_ch.time_step == '0) begin
							// zero step: hold state, flag it
							filtered_q <= sv_q;
							pass_q     <= 1'b0;
							err_q      <= 1'b1;
							state_q    <= S_OUT;
						end else begin
							state_q <= S_SETUP;
						end
					end
				end
				S_SETUP: state_q <= div_sat ? S_RATE : S_DIV;
				S_DIV: begin
					if (cnt_q == '0) begin
						state_q <= S_RATE;
					end
				end
				S_RATE: begin
					prev_q        <= x_q;
					value_phase_q <= 1'b0;
					state_q       <= S_P;
				end
				S_P: state_q <= cut_big ? S_BLEND : S_X;
				S_X: state_q <= (prod_q[PW-1:31] != '0) ? S_BLEND : S_XR;
				S_XR: state_q <= S_T1;
				S_T1: state_q <= S_T2;
				S_T2: state_q <= S_T3;
				S_T3: state_q <= (n_q == 4'(TAYLOR_TERMS)) ? S_K : S_T1;
				S_K: state_q <= (k_q == '0 || r_q == '0) ? S_W : S_K2;
				S_K2: state_q <= S_K;
				S_W: state_q <= S_BLEND;
				S_BLEND: state_q <= S_BL2;
				S_BL2: begin
					if (!value_phase_q) begin
						sd_q    <= bl_res[VW-1:0];
						state_q <= S_CUT;
					end else begin
						sv_q       <= bl_res[VW-1:0];
						filtered_q <= bl_res[VW-1:0];
						pass_q     <= 1'b0;
						err_q      <= 1'b0;
						state_q    <= S_OUT;
					end
				end
				S_CUT: state_q <= S_CUT2;
				S_CUT2: begin
					value_phase_q <= 1'b1;
					state_q       <= S_P;
				end
				S_OUT: begin
					if (out_ch.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			S_IDLE: begin
				x_q  <= in_ch.sample;
				dt_q <= in_ch.time_step;
			end
			S_SETUP: begin
				neg_q <= diff_neg;
				rem_q <= {1'b0, num_top};
				num_q <= num_full[VW:0];
				quo_q <= div_sat ? '1 : '0;
				cnt_q <= CNTW'(QW - 1);
			end
			S_DIV: begin
				rem_q <= div_ge ? div_sub[TIME_BITS-1:0] : div_sh[TIME_BITS-1:0];
				quo_q <= {quo_q[QW-2:0], div_ge};
				num_q <= num_q << 1;
				cnt_q <= cnt_q - 1'b1;
			end
			S_RATE: begin
				rate_q <= rate_full[VW-1:0];
				cut_q  <= CW'(derivative_cutoff_q);
			end
			S_P: begin
				if (cut_big) begin
					w_q <= '0;
				end
			end
			S_X: begin
				if (prod_q[PW-1:31] != '0) begin
					w_q <= '0;
				end
			end
			S_XR: begin
				k_q   <= x_round[58:52];
				f_q   <= {x_round[51:36], 16'd0};
				t_q   <= 33'(1) << 32;
				sum_q <= 35'(1) << 32;
				n_q   <= 4'd1;
			end
			S_T2: v_q <= prod_q[64:32];
			S_T3: begin
				t_q   <= q_fix;
				sum_q <= sum_new;
				n_q   <= n_q + 1'b1;
				r_q   <= sum_new[32:0];
			end
			S_K2: begin
				r_q <= prod_q[64:32];
				k_q <= k_q - 1'b1;
			end
			S_W: w_q <= w_round[32:16];
			S_CUT2: cut_q <= CW'(min_cutoff_q) + CW'(prod_q >> FB);
			default: ;
		endcase
	end

	assign in_ch.ready        = state_q == S_IDLE;
	assign out_ch.valid       = state_q == S_OUT;
	assign out_ch.filtered    = filtered_q;
	assign out_ch.passthrough = pass_q;
	assign out_ch.step_error  = err_q;

endmodule
`default_nettype wire
